/* rtl/qrtp_pkg.sv */
// ----------------------------------------------------------------------------
// qrtp_pkg
// Shared types and constants for the quaternion rigid point transform.
// ----------------------------------------------------------------------------
package qrtp_pkg;

  localparam int QUAT_W  = 16;
  localparam int COORD_W = 32;
  localparam int QPROD_W = 32;
  localparam int MAT_W   = 34;
  localparam int PROD_W  = MAT_W + COORD_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int FRAC_DROP = 30;
  localparam int RND_W   = ACC_W - FRAC_DROP;
  localparam int SUM_W   = RND_W + 1;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'sh2000_0000);
  localparam logic [1:0] REFRESH_CYC = 2'd2;

  typedef enum logic [2:0] {
    REG_QUAT_X  = 3'd0,
    REG_QUAT_Y  = 3'd1,
    REG_QUAT_Z  = 3'd2,
    REG_QUAT_W  = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } reg_idx_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MAT_W-1:0]   mat_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  function automatic mat_t ext_q(input logic signed [QPROD_W-1:0] v);
    ext_q = {{(MAT_W-QPROD_W){v[QPROD_W-1]}}, v};
  endfunction

endpackage

/* rtl/quaternion_rigid_transform_points_top.sv */
// ----------------------------------------------------------------------------
// quaternion_rigid_transform_points_top
// Rotates each point by the matrix expanded from the configured quaternion,
// adds the translation, rounds to Q16.16 and saturates each coordinate.
// ----------------------------------------------------------------------------
//  channel   ports                                   flow
//  input     in_valid/in_stall, in_x/y/z, last       one item per cycle unless stalled
//  output    out_valid/out_stall, out_x/y/z, last    one item per cycle unless stalled
//  config    psel/penable/pwrite/paddr/pwdata        APB, pready tied high
//
//  Four register stages: input, matrix products, row sums, translate and
//  saturate. An accepted item passes through them in that order.
//  Each stage advances while the stage after it is empty or moving, so
//  bubbles collapse and a stalled output holds only the stages behind it.
//  The matrix is rebuilt from the registers through the product and matrix
//  registers; in_stall stays high while it refreshes after reset and writes.
// ----------------------------------------------------------------------------
module quaternion_rigid_transform_points_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  qrtp_pkg::coord_t              in_x,
  input  qrtp_pkg::coord_t              in_y,
  input  qrtp_pkg::coord_t              in_z,
  input  logic                          in_point_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output qrtp_pkg::coord_t              out_x,
  output qrtp_pkg::coord_t              out_y,
  output qrtp_pkg::coord_t              out_z,
  output logic                          out_result_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qrtp_pkg::ADDR_W-1:0]   paddr,
  input  logic [qrtp_pkg::DATA_W-1:0]   pwdata,
  output logic [qrtp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import qrtp_pkg::*;

  logic signed [QUAT_W-1:0] qx_r, qy_r, qz_r, qw_r;
  coord_t                   tx_r, ty_r, tz_r;
  logic                     wr_en;
  reg_idx_t                 reg_idx;
  logic [1:0]               refresh_r;

  logic signed [QPROD_W-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  mat_t   mat_r [3][3];
  coord_t shift [3];

  logic   v1_r, v2_r, v3_r, v4_r;
  logic   rdy1, rdy2, rdy3, rdy4;
  logic   accept;
  coord_t p1_r [3];
  logic   l1_r, l2_r, l3_r, l4_r;
  prod_t  prod_r [3][3];
  acc_t   sum_r [3];
  coord_t res_r [3];

  logic signed [SUM_W-1:0] tsum [3];

  // configuration port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qx_r <= '0;
      qy_r <= '0;
      qz_r <= '0;
      qw_r <= 16'sd32767;
      tx_r <= '0;
      ty_r <= '0;
      tz_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_QUAT_X:  qx_r <= pwdata[QUAT_W-1:0];
        REG_QUAT_Y:  qy_r <= pwdata[QUAT_W-1:0];
        REG_QUAT_Z:  qz_r <= pwdata[QUAT_W-1:0];
        REG_QUAT_W:  qw_r <= pwdata[QUAT_W-1:0];
        REG_SHIFT_X: tx_r <= pwdata;
        REG_SHIFT_Y: ty_r <= pwdata;
        REG_SHIFT_Z: tz_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUAT_X:  prdata = {{(DATA_W-QUAT_W){qx_r[QUAT_W-1]}}, qx_r};
      REG_QUAT_Y:  prdata = {{(DATA_W-QUAT_W){qy_r[QUAT_W-1]}}, qy_r};
      REG_QUAT_Z:  prdata = {{(DATA_W-QUAT_W){qz_r[QUAT_W-1]}}, qz_r};
      REG_QUAT_W:  prdata = {{(DATA_W-QUAT_W){qw_r[QUAT_W-1]}}, qw_r};
      REG_SHIFT_X: prdata = tx_r;
      REG_SHIFT_Y: prdata = ty_r;
      REG_SHIFT_Z: prdata = tz_r;
      default:     prdata = '0;
    endcase
  end

  // hold input while the matrix catches up with the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_r <= REFRESH_CYC;
    end else if (wr_en) begin
      refresh_r <= REFRESH_CYC;
    end else if (refresh_r != 2'd0) begin
      refresh_r <= refresh_r - 2'd1;
    end
  end

  // quaternion component products
  always_ff @(posedge clk) begin
    xx_r <= qx_r * qx_r;
    yy_r <= qy_r * qy_r;
    zz_r <= qz_r * qz_r;
    ww_r <= qw_r * qw_r;
    xy_r <= qx_r * qy_r;
    wz_r <= qw_r * qz_r;
    xz_r <= qx_r * qz_r;
    wy_r <= qw_r * qy_r;
    yz_r <= qy_r * qz_r;
    wx_r <= qw_r * qx_r;
  end

  // rotation matrix, Q.30
  always_ff @(posedge clk) begin
    mat_r[0][0] <= ext_q(xx_r) - ext_q(yy_r) - ext_q(zz_r) + ext_q(ww_r);
    mat_r[0][1] <= (ext_q(xy_r) - ext_q(wz_r)) <<< 1;
    mat_r[0][2] <= (ext_q(xz_r) + ext_q(wy_r)) <<< 1;
    mat_r[1][0] <= (ext_q(xy_r) + ext_q(wz_r)) <<< 1;
    mat_r[1][1] <= ext_q(yy_r) + ext_q(ww_r) - ext_q(xx_r) - ext_q(zz_r);
    mat_r[1][2] <= (ext_q(yz_r) - ext_q(wx_r)) <<< 1;
    mat_r[2][0] <= (ext_q(xz_r) - ext_q(wy_r)) <<< 1;
    mat_r[2][1] <= (ext_q(yz_r) + ext_q(wx_r)) <<< 1;
    mat_r[2][2] <= ext_q(zz_r) + ext_q(ww_r) - ext_q(xx_r) - ext_q(yy_r);
  end

  // pipeline flow
  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1 || (refresh_r != 2'd0);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= accept;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r[0] <= in_x;
      p1_r[1] <= in_y;
      p1_r[2] <= in_z;
      l1_r    <= in_point_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= mat_r[i][j] * p1_r[j];
        end
      end
      l2_r <= l1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= acc_t'(prod_r[i][0]) + acc_t'(prod_r[i][1]) + acc_t'(prod_r[i][2])
                    + ROUND_BIAS;
      end
      l3_r <= l2_r;
    end
  end

  assign shift[0] = tx_r;
  assign shift[1] = ty_r;
  assign shift[2] = tz_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = SUM_W'($signed(sum_r[i][ACC_W-1:FRAC_DROP])) + SUM_W'(shift[i]);
    end
  end

  // drop fraction bits, translate, saturate
  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      for (int i = 0; i < 3; i++) begin
        if (!tsum[i][SUM_W-1] && (|tsum[i][SUM_W-2:COORD_W-1])) begin
          res_r[i] <= {1'b0, {(COORD_W-1){1'b1}}};
        end else if (tsum[i][SUM_W-1] && !(&tsum[i][SUM_W-2:COORD_W-1])) begin
          res_r[i] <= {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
          res_r[i] <= tsum[i][COORD_W-1:0];
        end
      end
      l4_r <= l3_r;
    end
  end

  assign out_valid       = v4_r;
  assign out_x           = res_r[0];
  assign out_y           = res_r[1];
  assign out_z           = res_r[2];
  assign out_result_last = l4_r;

`ifndef NO_ASSERTIONS
  a_hold_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> in_stall)
    else $error("input taken while matrix was refreshing");

  a_accept_refreshed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (refresh_r == 2'd0))
    else $error("item accepted with stale matrix");

  a_drain_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(!out_stall))
    else $error("result dropped without being taken");

  a_stage_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && out_stall && v3_r) |=> (v3_r && v4_r))
    else $error("pipeline stage lost an item during stall");
`endif

endmodule
